// ===== rtl/fntc_pkg.sv =====
// ----------------------------------------------------------------------------
// fntc_pkg
// Shared widths, register indexes, reset values and time constants for the
// frame number to timecode converter.
// ----------------------------------------------------------------------------
package fntc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_NOMINAL_FPS     = 3'd0;
  localparam cfg_idx_t REG_DROP_ENABLE     = 3'd1;
  localparam cfg_idx_t REG_DROP_PER_MINUTE = 3'd2;
  localparam cfg_idx_t REG_FRAMES_PER_TEN  = 3'd3;
  localparam cfg_idx_t REG_FRAMES_PER_DAY  = 3'd4;

  // register widths
  localparam int FPS_W    = 7;
  localparam int DROP_W   = 4;
  localparam int TEN_W    = 17;
  localparam int DAY_W    = 24;
  localparam int PERMIN_W = 13;
  localparam int HDIV_W   = 19;
  localparam int D9_W     = 8;

  // result field widths
  localparam int HOURS_W = 21;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int FRM_W   = 7;

  // extra bits that the added-back labels can need over the frame count
  localparam int ADD_HEADROOM = 8;

  // reset values
  localparam logic [FPS_W-1:0]  RST_NOMINAL_FPS     = 7'd30;
  localparam logic              RST_DROP_ENABLE     = 1'b0;
  localparam logic [DROP_W-1:0] RST_DROP_PER_MINUTE = 4'd2;
  localparam logic [TEN_W-1:0]  RST_FRAMES_PER_TEN  = 17'd17982;
  localparam logic [DAY_W-1:0]  RST_FRAMES_PER_DAY  = 24'd2589408;

  // time constants
  localparam logic [SEC_W-1:0]    SIXTY       = 6'd60;
  localparam logic [PERMIN_W-1:0] SECS_IN_MIN = 13'd60;
  localparam logic [HDIV_W-1:0]   SECS_IN_HOUR = 19'd3600;
  localparam logic [D9_W-1:0]     MINS_DROPPED_PER_TEN = 8'd9;

endpackage

// ===== rtl/fntc_if.sv =====
// ----------------------------------------------------------------------------
// fntc_in_if / fntc_out_if
// Valid/ready channels for frame numbers in and timecodes out.
// ----------------------------------------------------------------------------
interface fntc_in_if #(
  parameter int FRAME_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [FRAME_BITS-1:0] frame_number;

  modport source (output valid, output frame_number, input ready);
  modport sink   (input valid, input frame_number, output ready);
endinterface

interface fntc_out_if;
  logic                          valid;
  logic                          ready;
  logic [fntc_pkg::HOURS_W-1:0]  hours;
  logic [fntc_pkg::MIN_W-1:0]    minutes;
  logic [fntc_pkg::SEC_W-1:0]    seconds;
  logic [fntc_pkg::FRM_W-1:0]    frame_field;
  logic                          is_drop_format;

  modport source (output valid, output hours, output minutes, output seconds,
                  output frame_field, output is_drop_format, input ready);
  modport sink   (input valid, input hours, input minutes, input seconds,
                  input frame_field, input is_drop_format, output ready);
endinterface

// ===== rtl/frame_number_to_drop_frame_timecode.sv =====
// ----------------------------------------------------------------------------
// frame_number_to_drop_frame_timecode
// Converts a frame number to hours, minutes, seconds and frames, with
// optional drop-frame label correction and daily wrap.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_chan   in   valid / ready   frame_number
//  out_chan  out  valid / ready   hours, minutes, seconds, frame_field,
//                                 is_drop_format
//  cfg_*     in   cfg_we          cfg_index, cfg_wdata
//
//  One transaction per cycle sustained while the output is not held. The
//  pipeline is the chain of bit-per-stage dividers (day wrap and ten-minute
//  block, FRAME_BITS each; minute in the block, 17; hours, FRAME_BITS+8;
//  minutes, 19; seconds, 13) plus three register stages.
//  Reset is synchronous; it clears the valid bits and loads the configuration registers with their reset values.
//  When the output is held, the whole pipeline freezes; nothing is lost.
// ----------------------------------------------------------------------------
module frame_number_to_drop_frame_timecode #(
  parameter int FRAME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fntc_in_if.sink                        in_chan,
  fntc_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [fntc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fntc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int W2 = FRAME_BITS + fntc_pkg::ADD_HEADROOM;

  // configuration registers
  logic [fntc_pkg::FPS_W-1:0]  nominal_fps_r;
  logic                        drop_enable_r;
  logic [fntc_pkg::DROP_W-1:0] drop_per_minute_r;
  logic [fntc_pkg::TEN_W-1:0]  frames_per_ten_r;
  logic [fntc_pkg::DAY_W-1:0]  frames_per_day_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_fps_r     <= fntc_pkg::RST_NOMINAL_FPS;
      drop_enable_r     <= fntc_pkg::RST_DROP_ENABLE;
      drop_per_minute_r <= fntc_pkg::RST_DROP_PER_MINUTE;
      frames_per_ten_r  <= fntc_pkg::RST_FRAMES_PER_TEN;
      frames_per_day_r  <= fntc_pkg::RST_FRAMES_PER_DAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fntc_pkg::REG_NOMINAL_FPS:     nominal_fps_r     <= cfg_wdata[fntc_pkg::FPS_W-1:0];
        fntc_pkg::REG_DROP_ENABLE:     drop_enable_r     <= cfg_wdata[0];
        fntc_pkg::REG_DROP_PER_MINUTE: drop_per_minute_r <= cfg_wdata[fntc_pkg::DROP_W-1:0];
        fntc_pkg::REG_FRAMES_PER_TEN:  frames_per_ten_r  <= cfg_wdata[fntc_pkg::TEN_W-1:0];
        fntc_pkg::REG_FRAMES_PER_DAY:  frames_per_day_r  <= cfg_wdata[fntc_pkg::DAY_W-1:0];
        default: ;
      endcase
    end
  end

  // derived divisors, zero lengths mapped to one
  logic [fntc_pkg::FPS_W-1:0]    fps_eff;
  logic [fntc_pkg::TEN_W-1:0]    ten_eff;
  logic [fntc_pkg::PERMIN_W-1:0] fps_min;
  logic [fntc_pkg::HDIV_W-1:0]   fps_hour;
  logic [fntc_pkg::PERMIN_W-1:0] per_min;
  logic [fntc_pkg::D9_W-1:0]     drop9;
  logic                          day_wrap;

  always_comb begin
    fps_eff  = (nominal_fps_r == '0) ? fntc_pkg::FPS_W'(1) : nominal_fps_r;
    ten_eff  = (frames_per_ten_r == '0) ? fntc_pkg::TEN_W'(1) : frames_per_ten_r;
    fps_min  = fntc_pkg::PERMIN_W'(fps_eff) * fntc_pkg::SECS_IN_MIN;
    fps_hour = fntc_pkg::HDIV_W'(fps_eff) * fntc_pkg::SECS_IN_HOUR;
    per_min  = fps_min - fntc_pkg::PERMIN_W'(drop_per_minute_r);
    drop9    = fntc_pkg::D9_W'(drop_per_minute_r) * fntc_pkg::MINS_DROPPED_PER_TEN;
    day_wrap = drop_enable_r && (frames_per_day_r != '0);
  end

  // pipeline advance: freeze everything while the output is held
  logic out_vld_r;
  logic adv;
  assign adv           = !out_vld_r || out_chan.ready;
  assign in_chan.ready = adv;

  // day wrap
  logic                  d1_vld;
  logic [FRAME_BITS-1:0] d1_quo;
  logic [fntc_pkg::DAY_W-1:0] d1_rem;
  logic [FRAME_BITS:0]   d1_side;

  fntc_div #(.NUM_W(FRAME_BITS), .DEN_W(fntc_pkg::DAY_W), .SIDE_W(FRAME_BITS + 1)) u_div_day (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(in_chan.valid), .in_num(in_chan.frame_number), .in_den(frames_per_day_r),
    .in_side({in_chan.frame_number, drop_enable_r}),
    .out_valid(d1_vld), .out_quo(d1_quo), .out_rem(d1_rem), .out_side(d1_side)
  );

  logic [FRAME_BITS-1:0] fw;
  assign fw = day_wrap ? FRAME_BITS'(d1_rem) : d1_side[FRAME_BITS:1];

  // ten-minute blocks
  logic                       d2_vld;
  logic [FRAME_BITS-1:0]      d2_quo;
  logic [fntc_pkg::TEN_W-1:0] d2_rem;
  logic [FRAME_BITS:0]        d2_side;

  fntc_div #(.NUM_W(FRAME_BITS), .DEN_W(fntc_pkg::TEN_W), .SIDE_W(FRAME_BITS + 1)) u_div_ten (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(d1_vld), .in_num(fw), .in_den(ten_eff),
    .in_side({fw, d1_side[0] ^ (d1_quo[0] & 1'b0)}),
    .out_valid(d2_vld), .out_quo(d2_quo), .out_rem(d2_rem), .out_side(d2_side)
  );

  // whole minutes past the first one in the block
  logic [fntc_pkg::TEN_W-1:0] past_first;
  assign past_first = (d2_rem > fntc_pkg::TEN_W'(drop_per_minute_r))
                    ? d2_rem - fntc_pkg::TEN_W'(drop_per_minute_r) : '0;

  logic                          d3_vld;
  logic [fntc_pkg::TEN_W-1:0]    d3_quo;
  logic [fntc_pkg::PERMIN_W-1:0] d3_rem;
  logic [2*FRAME_BITS:0]         d3_side;

  fntc_div #(.NUM_W(fntc_pkg::TEN_W), .DEN_W(fntc_pkg::PERMIN_W),
             .SIDE_W(2*FRAME_BITS + 1)) u_div_min (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(d2_vld), .in_num(past_first), .in_den(per_min),
    .in_side({d2_quo, d2_side}),
    .out_valid(d3_vld), .out_quo(d3_quo), .out_rem(d3_rem), .out_side(d3_side)
  );

  // products of the label correction
  localparam int P2_W = fntc_pkg::TEN_W + fntc_pkg::DROP_W;

  logic                  m_vld_r;
  logic [W2-1:0]         p1_r;
  logic [P2_W-1:0]       p2_r;
  logic [FRAME_BITS-1:0] m_fw_r;
  logic                  m_drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r     <= W2'(d3_side[2*FRAME_BITS:FRAME_BITS+1]) * W2'(drop9);
      p2_r     <= P2_W'(d3_quo) * P2_W'(drop_per_minute_r) + P2_W'(d3_rem & '0);
      m_fw_r   <= d3_side[FRAME_BITS:1];
      m_drop_r <= d3_side[0];
    end
  end

  // corrected label count
  logic          a_vld_r;
  logic [W2-1:0] f2_r;
  logic          a_drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_r     <= m_drop_r ? W2'(m_fw_r) + p1_r + W2'(p2_r) : W2'(m_fw_r);
      a_drop_r <= m_drop_r;
    end
  end

  // hours: split by frames per hour
  localparam int S5_W = fntc_pkg::HOURS_W + 1;

  logic                        d4_vld;
  logic [W2-1:0]               d4_quo;
  logic [fntc_pkg::HDIV_W-1:0] d4_rem;
  logic                        d4_side;

  fntc_div #(.NUM_W(W2), .DEN_W(fntc_pkg::HDIV_W), .SIDE_W(1)) u_div_hour (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(a_vld_r), .in_num(f2_r), .in_den(fps_hour), .in_side(a_drop_r),
    .out_valid(d4_vld), .out_quo(d4_quo), .out_rem(d4_rem), .out_side(d4_side)
  );

  // minutes: split the rest of the hour by frames per minute
  logic                          d5_vld;
  logic [fntc_pkg::HDIV_W-1:0]   d5_quo;
  logic [fntc_pkg::PERMIN_W-1:0] d5_rem;
  logic [S5_W-1:0]               d5_side;

  fntc_div #(.NUM_W(fntc_pkg::HDIV_W), .DEN_W(fntc_pkg::PERMIN_W),
             .SIDE_W(S5_W)) u_div_minute (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(d4_vld), .in_num(d4_rem), .in_den(fps_min),
    .in_side({d4_quo[fntc_pkg::HOURS_W-1:0], d4_side}),
    .out_valid(d5_vld), .out_quo(d5_quo), .out_rem(d5_rem), .out_side(d5_side)
  );

  // seconds and frames: split the rest of the minute by the frame rate
  localparam int S6_W = fntc_pkg::MIN_W + S5_W;

  logic                          d6_vld;
  logic [fntc_pkg::PERMIN_W-1:0] d6_quo;
  logic [fntc_pkg::FPS_W-1:0]    d6_rem;
  logic [S6_W-1:0]               d6_side;

  fntc_div #(.NUM_W(fntc_pkg::PERMIN_W), .DEN_W(fntc_pkg::FPS_W),
             .SIDE_W(S6_W)) u_div_sec (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(d5_vld), .in_num(d5_rem), .in_den(fps_eff),
    .in_side({d5_quo[fntc_pkg::MIN_W-1:0], d5_side}),
    .out_valid(d6_vld), .out_quo(d6_quo), .out_rem(d6_rem), .out_side(d6_side)
  );

  // output register
  logic [fntc_pkg::HOURS_W-1:0] hours_r;
  logic [fntc_pkg::MIN_W-1:0]   minutes_r;
  logic [fntc_pkg::SEC_W-1:0]   seconds_r;
  logic [fntc_pkg::FRM_W-1:0]   frame_r;
  logic                         drop_fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= d6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hours_r    <= d6_side[S5_W-1:1];
      minutes_r  <= d6_side[S6_W-1:S5_W];
      seconds_r  <= d6_quo[fntc_pkg::SEC_W-1:0];
      frame_r    <= d6_rem;
      drop_fmt_r <= d6_side[0];
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.hours          = hours_r;
  assign out_chan.minutes        = minutes_r;
  assign out_chan.seconds        = seconds_r;
  assign out_chan.frame_field    = frame_r;
  assign out_chan.is_drop_format = drop_fmt_r;

endmodule

// ===== rtl/fntc_div.sv =====
// ----------------------------------------------------------------------------
// fntc_div
// Pipelined restoring divider, one quotient bit per stage, with a side
// payload and a valid bit travelling alongside. The divisor must hold steady
// while transactions are in flight.
// ----------------------------------------------------------------------------
module fntc_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 24,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [DEN_W-1:0]  out_rem,
  output logic [SIDE_W-1:0] out_side
);

  // stage inputs
  logic              s_vld  [0:NUM_W-1];
  logic [DEN_W-1:0]  s_rem  [0:NUM_W-1];
  logic [NUM_W-1:0]  s_nq   [0:NUM_W-1];
  logic [SIDE_W-1:0] s_side [0:NUM_W-1];

  // stage registers
  logic              vld_r  [0:NUM_W-1];
  logic [DEN_W-1:0]  rem_r  [0:NUM_W-1];
  logic [NUM_W-1:0]  nq_r   [0:NUM_W-1];
  logic [SIDE_W-1:0] side_r [0:NUM_W-1];

  genvar k;
  generate
    for (k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_nxt;
      logic [NUM_W-1:0] nq_nxt;

      // stage input selection
      if (k == 0) begin : g_first
        assign s_vld[k]  = in_valid;
        assign s_rem[k]  = '0;
        assign s_nq[k]   = in_num;
        assign s_side[k] = in_side;
      end else begin : g_next
        assign s_vld[k]  = vld_r[k-1];
        assign s_rem[k]  = rem_r[k-1];
        assign s_nq[k]   = nq_r[k-1];
        assign s_side[k] = side_r[k-1];
      end

      // one trial subtraction
      always_comb begin
        trial   = {s_rem[k], s_nq[k][NUM_W-1]};
        diff    = trial - {1'b0, in_den};
        ge      = (trial >= {1'b0, in_den});
        rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_nxt  = {s_nq[k][NUM_W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= s_vld[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= rem_nxt;
          nq_r[k]   <= nq_nxt;
          side_r[k] <= s_side[k];
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[NUM_W-1];
  assign out_quo   = nq_r[NUM_W-1];
  assign out_rem   = rem_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

// ===== rtl/fntc_check.sv =====
// ----------------------------------------------------------------------------
// fntc_check
// Port-level checks on the timecode converter, bound to the top level.
// ----------------------------------------------------------------------------
module fntc_check (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [fntc_pkg::MIN_W-1:0]   minutes,
  input logic [fntc_pkg::SEC_W-1:0]   seconds
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while held");

  // input is taken whenever the output is not held
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !out_ready) |-> in_ready)
    else $error("input stalled without output back-pressure");

  // minutes field in range
  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> minutes < fntc_pkg::SIXTY)
    else $error("minutes out of range");

  // seconds field in range
  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> seconds < fntc_pkg::SIXTY)
    else $error("seconds out of range");

endmodule

bind frame_number_to_drop_frame_timecode fntc_check u_fntc_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .minutes   (out_chan.minutes),
  .seconds   (out_chan.seconds)
);
